// ===== rtl/core/phcv_pkg.sv =====
`default_nettype none

package phcv_pkg;

  localparam int LEN_W  = 16;
  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam int MAX_PAYLOAD_DEF = 256;
  localparam int MID_DEPTH       = 4;
  localparam int OUT_DEPTH       = 2;

  localparam logic [BYTE_W-1:0] START_ONE_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] START_TWO_RST = 8'h55;

  typedef enum logic [0:0] {
    REG_START_ONE = 1'b0,
    REG_START_TWO = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_BAD_CRC    = 2'd3
  } status_t;

  // one classified item between front and back
  typedef struct packed {
    logic              is_payload;
    logic              hdr_good;
    logic              len_zero;
    logic              len_long;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  exp_crc;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  crc;
  } front_item_t;

  typedef struct packed {
    status_t          status;
    logic [CRC_W-1:0] crc;
  } result_t;

  localparam int ITEM_W   = $bits(front_item_t);
  localparam int RESULT_W = $bits(result_t);

  // CRC-16/MODBUS over one byte, LSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/phcv_fifo.sv =====
`default_nettype none

module phcv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phcv_front.sv =====
`default_nettype none

module phcv_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        req_type,
  input  wire logic [phcv_pkg::BYTE_W-1:0] first_start,
  input  wire logic [phcv_pkg::BYTE_W-1:0] second_start,
  input  wire logic [phcv_pkg::BYTE_W-1:0] command_byte,
  input  wire logic [phcv_pkg::BYTE_W-1:0] control_byte,
  input  wire logic [phcv_pkg::LEN_W-1:0]  payload_length,
  input  wire logic [phcv_pkg::CRC_W-1:0]  hdr_crc,
  input  wire logic [phcv_pkg::BYTE_W-1:0] data_byte,
  input  wire logic [phcv_pkg::BYTE_W-1:0] start_one,
  input  wire logic [phcv_pkg::BYTE_W-1:0] start_two,
  output logic                             q_push,
  output phcv_pkg::front_item_t            q_item,
  input  wire logic                        q_full
);

  import phcv_pkg::*;

  localparam int                NSTG    = 4;
  localparam logic [LEN_W:0]    MAX_LEN = (LEN_W + 1)'(MAX_PAYLOAD);

  front_item_t stg [NSTG];
  logic [NSTG-1:0] vld;
  front_item_t entry;
  front_item_t s1_next;
  front_item_t s2_next;
  front_item_t s3_next;
  logic advance;

  // whole pipe stalls only when the last stage cannot drain
  assign advance = !vld[NSTG-1] || !q_full;
  assign full    = !advance;
  assign q_push  = vld[NSTG-1] && !q_full;
  assign q_item  = stg[NSTG-1];

  always_comb begin
    entry.is_payload = req_type;
    entry.hdr_good   = (first_start == start_one) && (second_start == start_two);
    entry.len_zero   = (payload_length == '0);
    entry.len_long   = ({1'b0, payload_length} > MAX_LEN);
    entry.len        = payload_length;
    entry.exp_crc    = hdr_crc;
    entry.ctrl       = control_byte;
    entry.data       = data_byte;
    entry.crc        = crc_byte(CRC_INIT, command_byte);
  end

  // header CRC: one covered byte per stage
  always_comb begin
    s1_next = stg[0];
    s2_next = stg[1];
    s3_next = stg[2];
    s1_next.crc = crc_byte(stg[0].crc, stg[0].ctrl);
    s2_next.crc = crc_byte(stg[1].crc, stg[1].len[BYTE_W-1:0]);
    s3_next.crc = crc_byte(stg[2].crc, stg[2].len[LEN_W-1:BYTE_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NSTG-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg[0] <= entry;
      stg[1] <= s1_next;
      stg[2] <= s2_next;
      stg[3] <= s3_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phcv_back.sv =====
`default_nettype none

module phcv_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  input  wire phcv_pkg::front_item_t item,
  output logic                       take,
  input  wire logic                  res_full,
  output logic                       res_push,
  output phcv_pkg::result_t          res
);

  import phcv_pkg::*;

  logic [CRC_W-1:0] crc_acc;
  logic [CRC_W-1:0] crc_acc_next;
  logic [LEN_W-1:0] remaining;
  logic [LEN_W-1:0] remaining_next;
  logic             pkt_open;
  logic             pkt_open_next;
  logic             hdr_good;
  logic             hdr_good_next;
  logic [CRC_W-1:0] held_crc;
  logic [CRC_W-1:0] held_crc_next;
  logic [CRC_W-1:0] crc_step;

  assign take     = item_valid && !res_full;
  assign crc_step = crc_byte(crc_acc, item.data);

  always_comb begin
    crc_acc_next   = crc_acc;
    remaining_next = remaining;
    pkt_open_next  = pkt_open;
    hdr_good_next  = hdr_good;
    held_crc_next  = held_crc;
    res_push       = 1'b0;
    res.status     = ST_OK;
    res.crc        = crc_acc;
    if (take) begin
      if (!item.is_payload) begin
        crc_acc_next  = item.crc;
        hdr_good_next = item.hdr_good;
        held_crc_next = item.exp_crc;
        res.crc       = item.crc;
        if (item.len_long || item.len_zero) begin
          pkt_open_next  = 1'b0;
          remaining_next = '0;
          res_push       = 1'b1;
          priority if (!item.hdr_good) begin
            res.status = ST_BAD_HEADER;
          end else if (item.len_long) begin
            res.status = ST_BAD_LENGTH;
          end else if (item.crc != item.exp_crc) begin
            res.status = ST_BAD_CRC;
          end else begin
            res.status = ST_OK;
          end
        end else begin
          pkt_open_next  = 1'b1;
          remaining_next = item.len;
        end
      end else if (pkt_open) begin
        crc_acc_next   = crc_step;
        remaining_next = remaining - LEN_W'(1);
        res.crc        = crc_step;
        // last payload beat closes the packet
        if (remaining == LEN_W'(1)) begin
          pkt_open_next = 1'b0;
          res_push      = 1'b1;
          priority if (!hdr_good) begin
            res.status = ST_BAD_HEADER;
          end else if (crc_step != held_crc) begin
            res.status = ST_BAD_CRC;
          end else begin
            res.status = ST_OK;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc   <= CRC_INIT;
      remaining <= '0;
      pkt_open  <= 1'b0;
      hdr_good  <= 1'b0;
      held_crc  <= '0;
    end else begin
      crc_acc   <= crc_acc_next;
      remaining <= remaining_next;
      pkt_open  <= pkt_open_next;
      hdr_good  <= hdr_good_next;
      held_crc  <= held_crc_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/packet_header_crc_validator_core.sv =====
// Packet checker with CRC-16/MODBUS: takes one header beat and then payload byte beats,
// and returns one status and CRC per packet. One beat is accepted every cycle while
// full is low; a header's four covered bytes go through a four-stage CRC pipeline in
// the front, one byte per stage, and the back folds in one payload byte per cycle
// while the output queue has room. Beats pass through the front stages, then a
// four-entry queue between front and back; results wait in a two-entry output queue,
// so either side can stall without stopping the other at once.
`default_nettype none

module packet_header_crc_validator_core #(
  parameter int MAX_PAYLOAD = phcv_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        req_type,
  input  wire logic [phcv_pkg::BYTE_W-1:0] first_start,
  input  wire logic [phcv_pkg::BYTE_W-1:0] second_start,
  input  wire logic [phcv_pkg::BYTE_W-1:0] command_byte,
  input  wire logic [phcv_pkg::BYTE_W-1:0] control_byte,
  input  wire logic [phcv_pkg::LEN_W-1:0]  payload_length,
  input  wire logic [phcv_pkg::CRC_W-1:0]  hdr_crc,
  input  wire logic [phcv_pkg::BYTE_W-1:0] data_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [1:0]                       status,
  output logic [phcv_pkg::CRC_W-1:0]       calc_crc,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [0:0]                  cfg_index,
  input  wire logic [phcv_pkg::BYTE_W-1:0] cfg_data
);

  import phcv_pkg::*;

  logic [BYTE_W-1:0]   start_one;
  logic [BYTE_W-1:0]   start_two;
  logic                mid_push;
  front_item_t         mid_in;
  logic                mid_full;
  logic                mid_pop;
  logic [ITEM_W-1:0]   mid_raw;
  front_item_t         mid_head;
  logic                mid_empty;
  logic                res_push;
  result_t             res;
  logic                out_full;
  logic [RESULT_W-1:0] out_raw;
  result_t             out_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_one <= START_ONE_RST;
      start_two <= START_TWO_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_ONE: start_one <= cfg_data;
        REG_START_TWO: start_two <= cfg_data;
        default: ;
      endcase
    end
  end

  phcv_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .first_start   (first_start),
    .second_start  (second_start),
    .command_byte  (command_byte),
    .control_byte  (control_byte),
    .payload_length(payload_length),
    .hdr_crc       (hdr_crc),
    .data_byte     (data_byte),
    .start_one     (start_one),
    .start_two     (start_two),
    .q_push        (mid_push),
    .q_item        (mid_in),
    .q_full        (mid_full)
  );

  phcv_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (mid_push),
    .din  (mid_in),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_raw),
    .empty(mid_empty)
  );

  assign mid_head = front_item_t'(mid_raw);

  phcv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(!mid_empty),
    .item      (mid_head),
    .take      (mid_pop),
    .res_full  (out_full),
    .res_push  (res_push),
    .res       (res)
  );

  phcv_fifo #(
    .WIDTH(RESULT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (out_full),
    .pop  (pop),
    .dout (out_raw),
    .empty(empty)
  );

  assign out_head = result_t'(out_raw);
  assign status   = out_head.status;
  assign calc_crc = out_head.crc;

`ifndef SYNTH
  a_res_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result produced while output queue full");

  a_res_from_item: assert property (@(posedge clk) disable iff (rst)
    res_push |-> mid_pop)
    else $error("result produced without a consumed beat");

  a_early_answer: assert property (@(posedge clk) disable iff (rst)
    (mid_pop && !mid_head.is_payload && (mid_head.len_long || mid_head.len_zero))
      |-> res_push)
    else $error("zero or oversize header gave no result");

  a_bad_len_on_header: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == ST_BAD_LENGTH) |-> (!mid_head.is_payload && mid_head.len_long))
    else $error("bad length status not from an oversize header");
`endif

endmodule

`default_nettype wire
